@@ design/sha1_pkg.sv @@
// Shared types and constants for the SHA-1 hash engine.
`timescale 1ns / 1ps
package sha1_pkg;

   localparam logic [31:0] H0 = 32'h6745_2301;
   localparam logic [31:0] H1 = 32'hEFCD_AB89;
   localparam logic [31:0] H2 = 32'h98BA_DCFE;
   localparam logic [31:0] H3 = 32'h1032_5476;
   localparam logic [31:0] H4 = 32'hC3D2_E1F0;

   localparam logic [31:0] K0 = 32'h5A82_7999;
   localparam logic [31:0] K1 = 32'h6ED9_EBA1;
   localparam logic [31:0] K2 = 32'h8F1B_BCDC;
   localparam logic [31:0] K3 = 32'hCA62_C1D6;

   localparam logic [31:0] PAD_MARKER = 32'h8000_0000;

   localparam logic [6:0] ROUND_K1_START = 7'd20;
   localparam logic [6:0] ROUND_K2_START = 7'd40;
   localparam logic [6:0] ROUND_K3_START = 7'd60;
   localparam logic [6:0] LAST_ROUND     = 7'd79;

   localparam logic [3:0] LAST_SLOT       = 4'd15;
   localparam logic [3:0] LEN_HI_SLOT     = 4'd14;
   localparam logic [3:0] LAST_MARKER_FIT = 4'd13;

   localparam logic [2:0] FULL_WORD_BYTES = 3'd4;
   localparam logic [2:0] LAST_DIGEST     = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } sha1_state_type;

   typedef struct packed {
      logic        load;
      logic [31:0] load_data;
      logic        init;
      logic        round;
      logic        finish;
      logic        restart;
      logic [2:0]  sel;
   } sha1_cmd_type;

   typedef struct packed {
      logic        round_last;
      logic [31:0] digest_word;
   } sha1_stat_type;

endpackage

@@ design/sha1_stream_if.sv @@
// Request and response channel interfaces of the SHA-1 hash engine.
`timescale 1ns / 1ps
interface sha1_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_word;
   logic [2:0]  valid_bytes;
   logic        final_word;

   modport source (output valid, message_word, valid_bytes, final_word, input ready);
   modport sink   (input valid, message_word, valid_bytes, final_word, output ready);
endinterface

interface sha1_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        digest_last;

   modport source (output valid, digest_word, digest_last, input ready);
   modport sink   (input valid, digest_word, digest_last, output ready);
endinterface

@@ design/sha1_hash_engine.sv @@
// Top level of the streaming SHA-1 hash engine: sequencer, padding and length tracking.
//
//   channel  dir  payload                                   handshake
//   req_if   in   message_word[31:0] valid_bytes[2:0] final_word   valid/ready
//   rsp_if   out  digest_word[31:0] digest_last                    valid/ready
//
// A message word is taken whenever the engine is idle. The word that fills a 64-byte block
// starts the shared round unit: 80 rounds at one per cycle plus an add step,
// and no new request is taken until that compression is done.
// A final word writes up to 18 padding words at one per cycle, held while one or
// two compressions run, then offers five digest words; ready stays low until the last
// is taken. Reset loads the initial chaining values; rsp stalls simply hold.
`timescale 1ns / 1ps
module sha1_hash_engine
   import sha1_pkg::*;
(
   input logic          clock,
   input logic          reset,
   sha1_req_if.sink     req_if,
   sha1_rsp_if.source   rsp_if
);

   sha1_state_type state_ff, state_in;
   logic [3:0]     wcnt_ff, wcnt_in;
   logic [63:0]    len_ff, len_in;
   logic           marker_ff, marker_in;
   logic           len_ok_ff, len_ok_in;
   logic           pad_ff, pad_in;
   logic           last_ff, last_in;
   logic [2:0]     osel_ff, osel_in;
   sha1_cmd_type   cmd;
   sha1_stat_type  stat;
   logic [2:0]     byte_cnt;
   logic [31:0]    tail_word;
   logic           req_take, rsp_take;

   function automatic logic [31:0] mark_tail(input logic [31:0] w, input logic [2:0] n);
      case (n)
         3'd0:    mark_tail = PAD_MARKER;
         3'd1:    mark_tail = {w[31:24], 24'h80_0000};
         3'd2:    mark_tail = {w[31:16], 16'h8000};
         3'd3:    mark_tail = {w[31:8], 8'h80};
         default: mark_tail = w;
      endcase
   endfunction

   sha1_round_core u_core (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign byte_cnt  = (req_if.valid_bytes > FULL_WORD_BYTES) ? FULL_WORD_BYTES
                                                             : req_if.valid_bytes;
   assign tail_word = mark_tail(req_if.message_word, byte_cnt);
   assign req_take  = req_if.valid && req_if.ready;
   assign rsp_take  = rsp_if.valid && rsp_if.ready;

   always_comb begin
      state_in  = state_ff;
      wcnt_in   = wcnt_ff;
      len_in    = len_ff;
      marker_in = marker_ff;
      len_ok_in = len_ok_ff;
      pad_in    = pad_ff;
      last_in   = last_ff;
      osel_in   = osel_ff;
      cmd       = '0;
      cmd.sel   = osel_ff;
      req_if.ready       = 1'b0;
      rsp_if.valid       = 1'b0;
      rsp_if.digest_word = stat.digest_word;
      rsp_if.digest_last = (osel_ff == LAST_DIGEST);
      case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_take) begin
               cmd.load = 1'b1;
               wcnt_in  = wcnt_ff + 4'd1;
               if (req_if.final_word) begin
                  cmd.load_data = tail_word;
                  len_in        = len_ff + {61'd0, byte_cnt};
                  pad_in        = 1'b1;
                  last_in       = 1'b0;
                  marker_in     = (byte_cnt == FULL_WORD_BYTES);
                  len_ok_in     = (byte_cnt != FULL_WORD_BYTES) && (wcnt_ff <= LAST_MARKER_FIT);
                  state_in      = ST_PAD;
               end else begin
                  cmd.load_data = req_if.message_word;
                  len_in        = len_ff + 64'd4;
               end
               if (wcnt_ff == LAST_SLOT) begin
                  cmd.init = 1'b1;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_PAD: begin
            cmd.load = 1'b1;
            wcnt_in  = wcnt_ff + 4'd1;
            if (marker_ff) begin
               cmd.load_data = PAD_MARKER;
               marker_in     = 1'b0;
               len_ok_in     = (wcnt_ff <= LAST_MARKER_FIT);
            end else if (len_ok_ff && wcnt_ff == LEN_HI_SLOT) begin
               cmd.load_data = len_ff[60:29];
            end else if (len_ok_ff && wcnt_ff == LAST_SLOT) begin
               cmd.load_data = {len_ff[28:0], 3'b000};
               last_in       = 1'b1;
            end else begin
               cmd.load_data = '0;
            end
            if (wcnt_ff == LAST_SLOT) begin
               cmd.init = 1'b1;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (stat.round_last) state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.finish = 1'b1;
            if (!pad_ff) begin
               state_in = ST_IDLE;
            end else if (last_ff) begin
               osel_in  = '0;
               state_in = ST_OUT;
            end else begin
               len_ok_in = 1'b1;
               state_in  = ST_PAD;
            end
         end
         ST_OUT: begin
            rsp_if.valid = 1'b1;
            if (rsp_take) begin
               osel_in = osel_ff + 3'd1;
               if (osel_ff == LAST_DIGEST) begin
                  cmd.restart = 1'b1;
                  len_in      = '0;
                  wcnt_in     = '0;
                  pad_in      = 1'b0;
                  last_in     = 1'b0;
                  osel_in     = '0;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wcnt_ff   <= '0;
         len_ff    <= '0;
         marker_ff <= 1'b0;
         len_ok_ff <= 1'b0;
         pad_ff    <= 1'b0;
         last_ff   <= 1'b0;
         osel_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         wcnt_ff   <= wcnt_in;
         len_ff    <= len_in;
         marker_ff <= marker_in;
         len_ok_ff <= len_ok_in;
         pad_ff    <= pad_in;
         last_ff   <= last_in;
         osel_ff   <= osel_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("request taken while digest pending");

   a_digest_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && pad_ff && last_ff) |=> rsp_if.valid)
      else $error("digest not offered after final compression");

   a_rounds_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && !stat.round_last) |=> (state_ff == ST_ROUND))
      else $error("round sequence cut short");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_if.digest_last) |=> (req_if.ready && wcnt_ff == 4'd0 && len_ff == 64'd0))
      else $error("engine not restarted after digest");

endmodule

@@ design/sha1_round_core.sv @@
// SHA-1 datapath: schedule shift line, working variables, chaining words, round unit.
`timescale 1ns / 1ps
module sha1_round_core
   import sha1_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  sha1_cmd_type  cmd,
   output sha1_stat_type stat
);

   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [6:0]  rcnt_ff, rcnt_in;
   logic [31:0] f_val, k_val, w_next, temp;

   always_comb begin
      if (rcnt_ff < ROUND_K1_START) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K0;
      end else if (rcnt_ff < ROUND_K2_START) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K1;
      end else if (rcnt_ff < ROUND_K3_START) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K3;
      end
      w_next = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      temp   = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_ff[0];
   end

   always_comb begin
      w_in    = w_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      d_in    = d_ff;
      e_in    = e_ff;
      h_in    = h_ff;
      rcnt_in = rcnt_ff;
      if (cmd.load || cmd.round) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = cmd.load ? cmd.load_data : {w_next[30:0], w_next[31]};
      end
      if (cmd.init) begin
         a_in    = h_ff[0];
         b_in    = h_ff[1];
         c_in    = h_ff[2];
         d_in    = h_ff[3];
         e_in    = h_ff[4];
         rcnt_in = '0;
      end else if (cmd.round) begin
         e_in    = d_ff;
         d_in    = c_ff;
         c_in    = {b_ff[1:0], b_ff[31:2]};
         b_in    = a_ff;
         a_in    = temp;
         rcnt_in = rcnt_ff + 7'd1;
      end
      if (cmd.finish) begin
         h_in[0] = h_ff[0] + a_ff;
         h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
      end else if (cmd.restart) begin
         h_in[0] = H0;
         h_in[1] = H1;
         h_in[2] = H2;
         h_in[3] = H3;
         h_in[4] = H4;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff[0] <= H0;
         h_ff[1] <= H1;
         h_ff[2] <= H2;
         h_ff[3] <= H3;
         h_ff[4] <= H4;
         rcnt_ff <= '0;
      end else begin
         h_ff    <= h_in;
         rcnt_ff <= rcnt_in;
      end
   end

   always_comb begin
      stat.round_last = (rcnt_ff == LAST_ROUND);
      case (cmd.sel)
         3'd0:    stat.digest_word = h_ff[0];
         3'd1:    stat.digest_word = h_ff[1];
         3'd2:    stat.digest_word = h_ff[2];
         3'd3:    stat.digest_word = h_ff[3];
         default: stat.digest_word = h_ff[4];
      endcase
   end

endmodule

@@ sim/tb_sha1_hash_engine.sv @@
// Self-checking testbench for the streaming SHA-1 hash engine.
`timescale 1ns / 1ps
module tb_sha1_hash_engine
   import sha1_pkg::*;
();

   localparam int RANDOM_ITEMS = 250;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 100;

   class sha1_digest_model;
      typedef struct packed {
         logic [31:0] word;
         logic        last;
      } digest_item_type;

      logic [31:0]     chain[5];
      logic [31:0]     sched[16];
      logic [63:0]     byte_count;
      digest_item_type expected_digests[$];

      function new();
         restart();
      endfunction

      function void restart();
         chain[0] = H0;
         chain[1] = H1;
         chain[2] = H2;
         chain[3] = H3;
         chain[4] = H4;
         byte_count = '0;
      endfunction

      function void compress();
         logic [31:0] a, b, c, d, e, f, k, w, t;
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         e = chain[4];
         for (int r = 0; r < 80; r++) begin
            if (r >= 16) begin
               w = sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^ sched[(r + 2) & 15]
                   ^ sched[r & 15];
               w = {w[30:0], w[31]};
               sched[r & 15] = w;
            end else begin
               w = sched[r];
            end
            if (r < ROUND_K1_START) begin
               f = (b & c) | (~b & d);
               k = K0;
            end else if (r < ROUND_K2_START) begin
               f = b ^ c ^ d;
               k = K1;
            end else if (r < ROUND_K3_START) begin
               f = (b & c) | (b & d) | (c & d);
               k = K2;
            end else begin
               f = b ^ c ^ d;
               k = K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
         chain[4] += e;
      endfunction

      function void note_request(logic [31:0] word, logic [2:0] count_in, logic fin);
         int              idx;
         int              nbytes;
         logic [31:0]     keep;
         logic [31:0]     padded;
         logic [63:0]     bits;
         digest_item_type item;
         idx = byte_count[5:2];
         if (!fin) begin
            sched[idx] = word;
            byte_count += 4;
            if (idx == 15) compress();
            return;
         end
         nbytes = (count_in > FULL_WORD_BYTES) ? FULL_WORD_BYTES : count_in;
         padded = word;
         if (nbytes < FULL_WORD_BYTES) begin
            keep = (nbytes == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * nbytes));
            padded = (word & keep) | (32'h80 << (24 - 8 * nbytes));
         end
         byte_count += nbytes;
         sched[idx] = padded;
         idx++;
         if (nbytes == FULL_WORD_BYTES) begin
            if (idx == 16) begin
               compress();
               idx = 0;
            end
            sched[idx] = PAD_MARKER;
            idx++;
         end
         // marker in the last two slots: no room for the length
         if (idx > 14) begin
            while (idx < 16) begin
               sched[idx] = '0;
               idx++;
            end
            compress();
            idx = 0;
         end
         while (idx < 14) begin
            sched[idx] = '0;
            idx++;
         end
         bits = byte_count << 3;
         sched[14] = bits[63:32];
         sched[15] = bits[31:0];
         compress();
         for (int i = 0; i < 5; i++) begin
            item.word = chain[i];
            item.last = (i == 4);
            expected_digests.push_back(item);
         end
         restart();
      endfunction

      function string check_digest(logic [31:0] word, logic last);
         digest_item_type item;
         if (expected_digests.size() == 0)
            return $sformatf("unexpected digest word %08h last=%0b", word, last);
         item = expected_digests.pop_front();
         if (word !== item.word || last !== item.last)
            return $sformatf("digest word %08h last=%0b, expected %08h last=%0b",
                             word, last, item.word, item.last);
         return "";
      endfunction

      function int pending();
         return expected_digests.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   sha1_req_if req_if();
   sha1_rsp_if rsp_if();

   sha1_hash_engine u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   sha1_digest_model sb;
   int               error_count = 0;
   int               idle_cycles = 0;
   int               burst_left  = 0;
   logic [7:0]       stall_phase;
   string            rsp_msg;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("MISMATCH at %0t ns: %s", $time, msg);
   endtask

   task automatic send_request(input logic [31:0] word, input logic [2:0] cnt,
                               input logic fin);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_if.valid        <= 1'b1;
      req_if.message_word <= word;
      req_if.valid_bytes  <= cnt;
      req_if.final_word   <= fin;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(word, cnt, fin);
      burst_left--;
   endtask

   task automatic send_message(input logic [31:0] body[$], input logic [2:0] tail_count);
      for (int i = 0; i < body.size(); i++) begin
         if (i == body.size() - 1)
            send_request(body[i], tail_count, 1'b1);
         else
            send_request(body[i], 3'($urandom_range(0, 7)), 1'b0);
      end
   endtask

   task automatic wait_for_digests();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_phase  <= '0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_msg = sb.check_digest(rsp_if.digest_word, rsp_if.digest_last);
            if (rsp_msg != "") report_mismatch(rsp_msg);
         end
         stall_phase <= stall_phase + 8'd1;
         case (stall_phase[7:6])
            2'd0: rsp_if.ready <= 1'b1;
            2'd1: rsp_if.ready <= 1'($urandom_range(0, 1));
            2'd2: rsp_if.ready <= ($urandom_range(0, 7) == 0);
            default: rsp_if.ready <= stall_phase[2];
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [31:0] words[$];
      int          random_items;
      int          len;
      int          pick;
      sb = new();
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.message_word = '0;
      req_if.valid_bytes  = '0;
      req_if.final_word   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty message, short tails, oversized count
      words = {$urandom()};
      send_message(words, 3'd0);
      words = {32'h6162_6300};
      send_message(words, 3'd3);
      words = {32'hFFFF_FFFF};
      send_message(words, 3'd7);
      words = {32'h1234_5678};
      send_message(words, 3'd1);
      words = {32'hA5A5_5A5A};
      send_message(words, 3'd2);
      // full final word puts the marker in slot 14: length spills to a second block
      words = {};
      for (int i = 0; i < 14; i++) words.push_back(i[0] ? 32'hFFFF_FFFF : 32'h0);
      send_message(words, FULL_WORD_BYTES);
      wait_for_digests();

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 4)      len = $urandom_range(1, 6);
         else if (pick < 8) len = $urandom_range(12, 18);
         else               len = $urandom_range(28, 34);
         words = {};
         for (int i = 0; i < len; i++) words.push_back($urandom());
         send_message(words, 3'($urandom_range(0, 7)));
         random_items += len;
         if ($urandom_range(0, 5) == 0) wait_for_digests();
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         report_mismatch($sformatf("%0d digest words never arrived", sb.pending()));
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
